@@ rtl/dpt_pkg.sv @@
// Shared types, constants and the pattern-letter lookup for the date pattern tokenizer.
package dpt_pkg;

    // Field widths fixed by the item format and by the upper limit of the quote depth.
    localparam int CNT_W   = 16;
    localparam int TAG_W   = 5;
    localparam int LEN_W   = 6;
    localparam int TOT_W   = 7;
    localparam int NOUT_W  = 6;
    localparam int MAX_OUT = 36;

    // Character and tag codes.
    localparam logic [7:0]       QUOTE_CHAR = 8'h27;
    localparam logic [7:0]       TAG_ASCII  = 8'd100;
    localparam logic [7:0]       TAG_CHARS  = 8'd101;
    localparam logic [TAG_W-1:0] TAG_MONTH  = 5'd2;
    localparam logic [TAG_W-1:0] TAG_ISO    = 5'd21;
    localparam logic [TAG_W-1:0] TAG_NONE   = 5'd23;
    localparam logic [CNT_W-1:0] CNT_MAX    = 16'hffff;

    // Error codes carried on an error transaction.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_ILLEGAL = 3'd1;
    localparam logic [2:0] ERR_ISO     = 3'd2;
    localparam logic [2:0] ERR_UNTERM  = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    // Work description of one accepted pattern byte, in emission order.
    typedef struct packed {
        logic             fl1_en;
        logic [TAG_W-1:0] fl1_tag;
        logic [CNT_W-1:0] fl1_cnt;
        logic             drn_en;
        logic [LEN_W-1:0] drn_len;
        logic             drn_short;
        logic             ch_en;
        logic [7:0]       ch_byte;
        logic             fl2_en;
        logic [TAG_W-1:0] fl2_tag;
        logic [CNT_W-1:0] fl2_cnt;
        logic             mark_en;
        logic [2:0]       err;
        logic             fin;
        logic             smonth;
        logic [TOT_W-1:0] total;
    } t_cmd;

    // Write port of the quoted-text buffer.
    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } t_qwr;

    // Maps a pattern letter to its tag; TAG_NONE for any other byte.
    function automatic logic [TAG_W-1:0] letter_tag(input logic [7:0] c);
        logic [TAG_W-1:0] t;
        case (c)
            "G": t = 5'd0;
            "y": t = 5'd1;
            "M": t = 5'd2;
            "d": t = 5'd3;
            "k": t = 5'd4;
            "H": t = 5'd5;
            "m": t = 5'd6;
            "s": t = 5'd7;
            "S": t = 5'd8;
            "E": t = 5'd9;
            "D": t = 5'd10;
            "F": t = 5'd11;
            "w": t = 5'd12;
            "W": t = 5'd13;
            "a": t = 5'd14;
            "h": t = 5'd15;
            "K": t = 5'd16;
            "z": t = 5'd17;
            "Z": t = 5'd18;
            "Y": t = 5'd19;
            "u": t = 5'd20;
            "X": t = 5'd21;
            "L": t = 5'd22;
            default: t = TAG_NONE;
        endcase
        return t;
    endfunction

    // Number of units a letter run produces.
    function automatic logic [1:0] run_units(input logic [CNT_W-1:0] cnt);
        return (cnt < 16'd255) ? 2'd1 : 2'd3;
    endfunction

endpackage

@@ rtl/dpt_front.sv @@
// Front end: accepts pattern bytes, tracks pattern state and issues at most one work command per byte.
module dpt_front
    import dpt_pkg::*;
#(
    parameter int QUOTE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_pattern_byte,
    input  logic       i_end_of_pattern,
    input  logic       i_q_full,
    input  logic       i_drain_done,
    output logic       o_push,
    output t_cmd       o_cmd,
    output t_qwr       o_qwr
);

    logic             r_in_quote, n_in_quote;
    logic             r_pending, n_pending;
    logic [TAG_W-1:0] r_run_tag, n_run_tag;
    logic             r_run_active, n_run_active;
    logic [CNT_W-1:0] r_run_count, n_run_count;
    logic [1:0]       r_lrs, n_lrs;
    logic [TAG_W-1:0] r_prev_tag, n_prev_tag;
    logic [LEN_W-1:0] r_qlen, n_qlen;
    logic             r_q0_hi, n_q0_hi;
    logic             r_discard, n_discard;
    logic             r_drain_busy, n_drain_busy;
    logic             accept;
    t_cmd             cmd;
    t_qwr             qwr;

    // Items wait while the queue is full or quoted text is still being read out.
    assign o_in_stall = i_q_full | r_drain_busy;
    assign accept     = i_in_valid & ~o_in_stall;

    // Classification of the byte and the resulting state and command.
    always_comb begin
        logic [7:0]       c;
        logic             last;
        logic             isq;
        logic             is_letter;
        logic [TAG_W-1:0] tidx;
        logic             pre_flush;
        logic             pre_iso;
        logic             do_open;
        logic             do_close;
        logic             buf_req;
        logic [7:0]       buf_data;
        logic             new_run;
        logic [2:0]       fault;
        logic [LEN_W-1:0] base;
        logic             act1;
        logic [CNT_W-1:0] cnt1;
        logic [1:0]       lrs1;
        logic [TAG_W-1:0] prev1;
        logic [TAG_W-1:0] tag1;
        logic             iq_post;
        logic             post_iso;
        logic [1:0]       lrs2;
        logic [TAG_W-1:0] prev2;
        logic [TOT_W-1:0] n_fl1;
        logic [TOT_W-1:0] n_drn;
        logic [TOT_W-1:0] n_ch;
        logic [TOT_W-1:0] n_fl2;
        logic [TOT_W-1:0] sum;

        c         = i_pattern_byte;
        last      = i_end_of_pattern;
        isq       = (c == QUOTE_CHAR);
        is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        tidx      = letter_tag(c);
        pre_iso   = r_run_active && (r_run_tag == TAG_ISO) && (r_run_count >= 16'd4);
        pre_flush = 1'b0;
        do_open   = 1'b0;
        do_close  = 1'b0;
        buf_req   = 1'b0;
        buf_data  = c;
        new_run   = 1'b0;
        fault     = ERR_NONE;
        cmd       = '0;
        qwr       = '0;

        n_in_quote   = r_in_quote;
        n_pending    = r_pending;
        n_run_tag    = r_run_tag;
        n_run_active = r_run_active;
        n_run_count  = r_run_count;
        n_lrs        = r_lrs;
        n_prev_tag   = r_prev_tag;
        n_qlen       = r_qlen;
        n_q0_hi      = r_q0_hi;
        n_discard    = r_discard;

        // Quote handling with one byte of lookahead, then the ordinary byte.
        if (isq) begin
            if (r_pending) begin
                n_pending = 1'b0;
                pre_flush = 1'b1;
                if (!pre_iso) begin
                    if (r_in_quote) begin
                        buf_req  = 1'b1;
                        buf_data = QUOTE_CHAR;
                    end else begin
                        cmd.ch_en   = 1'b1;
                        cmd.ch_byte = QUOTE_CHAR;
                    end
                end
            end else if (last) begin
                if (!r_in_quote) begin
                    pre_flush = 1'b1;
                    do_open   = !pre_iso;
                end else begin
                    do_close = 1'b1;
                end
            end else begin
                n_pending = 1'b1;
            end
        end else begin
            if (r_pending) begin
                n_pending = 1'b0;
                if (!r_in_quote) begin
                    pre_flush = 1'b1;
                    do_open   = !pre_iso;
                end else begin
                    do_close = 1'b1;
                end
            end
            if (!(pre_flush && pre_iso)) begin
                if (do_open || (r_in_quote && !do_close)) begin
                    buf_req  = 1'b1;
                    buf_data = c;
                end else if (!is_letter) begin
                    pre_flush = 1'b1;
                    if (!pre_iso) begin
                        cmd.ch_en   = 1'b1;
                        cmd.ch_byte = c;
                    end
                end else if (tidx == TAG_NONE) begin
                    fault = ERR_ILLEGAL;
                end else begin
                    if (r_run_active && (r_run_tag != tidx)) begin
                        pre_flush = 1'b1;
                    end
                    new_run = !(pre_flush && pre_iso);
                end
            end
        end

        if (pre_flush && pre_iso) begin
            fault = ERR_ISO;
        end

        // Flush of the run that was open before this byte.
        cmd.fl1_en  = pre_flush && r_run_active && !pre_iso;
        cmd.fl1_tag = r_run_tag;
        cmd.fl1_cnt = r_run_count;

        // Closing quote: the buffered text is read out by the back end.
        cmd.drn_en    = do_close;
        cmd.drn_len   = r_qlen;
        cmd.drn_short = (r_qlen == LEN_W'(1)) && !r_q0_hi;

        // Buffered byte, with overflow check.
        base = do_open ? '0 : r_qlen;
        if (buf_req && (fault == ERR_NONE)) begin
            if (base >= LEN_W'(QUOTE_DEPTH)) begin
                fault = ERR_OVERFLOW;
            end else begin
                qwr.en   = accept;
                qwr.addr = base;
                qwr.data = buf_data;
                n_qlen   = base + LEN_W'(1);
                if (base == '0) begin
                    n_q0_hi = buf_data[7];
                end
            end
        end else if (do_open) begin
            n_qlen = '0;
        end

        // Run state after this byte.
        act1  = cmd.fl1_en ? 1'b0 : r_run_active;
        cnt1  = cmd.fl1_en ? '0 : r_run_count;
        lrs1  = (cmd.fl1_en && (r_lrs != 2'd3)) ? r_lrs + 2'd1 : r_lrs;
        prev1 = cmd.fl1_en ? r_run_tag : r_prev_tag;
        tag1  = r_run_tag;
        if (new_run) begin
            act1 = 1'b1;
            tag1 = tidx;
            cnt1 = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + 16'd1;
        end
        iq_post = do_open || (r_in_quote && !do_close);

        // End of pattern: final flush, end marker and month flag.
        post_iso = act1 && (tag1 == TAG_ISO) && (cnt1 >= 16'd4);
        lrs2     = lrs1;
        prev2    = prev1;
        if (last && (fault == ERR_NONE)) begin
            if (iq_post) begin
                fault = ERR_UNTERM;
            end else if (post_iso) begin
                fault = ERR_ISO;
            end else begin
                cmd.fl2_en  = act1;
                cmd.fl2_tag = tag1;
                cmd.fl2_cnt = cnt1;
                if (act1) begin
                    lrs2  = (lrs1 != 2'd3) ? lrs1 + 2'd1 : lrs1;
                    prev2 = tag1;
                end
                cmd.fin    = 1'b1;
                cmd.smonth = (lrs2 == 2'd1) && (prev2 == TAG_MONTH);
            end
        end
        cmd.err = fault;

        // Transaction count of this byte.
        n_fl1 = cmd.fl1_en ? TOT_W'(run_units(cmd.fl1_cnt)) : '0;
        n_drn = !cmd.drn_en ? '0 :
                cmd.drn_short ? TOT_W'(1) : TOT_W'(cmd.drn_len) + TOT_W'(1);
        n_ch  = !cmd.ch_en ? '0 : (cmd.ch_byte[7] ? TOT_W'(2) : TOT_W'(1));
        n_fl2 = cmd.fl2_en ? TOT_W'(run_units(cmd.fl2_cnt)) : '0;
        sum   = n_fl1 + n_drn + n_ch + n_fl2;
        cmd.mark_en = cmd.fin && (sum == '0);
        cmd.total   = sum + TOT_W'(cmd.mark_en) + TOT_W'(fault != ERR_NONE);

        // Commit, clear on end or fault.
        n_in_quote   = iq_post;
        n_run_active = act1;
        n_run_tag    = tag1;
        n_run_count  = cnt1;
        n_lrs        = lrs1;
        n_prev_tag   = prev1;
        if (last || (fault != ERR_NONE)) begin
            n_in_quote   = 1'b0;
            n_pending    = 1'b0;
            n_run_tag    = '0;
            n_run_active = 1'b0;
            n_run_count  = '0;
            n_lrs        = '0;
            n_prev_tag   = '0;
            n_qlen       = '0;
            n_discard    = (fault != ERR_NONE) && !last;
        end

        // Discard mode overrides everything until the end of the pattern.
        if (r_discard) begin
            cmd          = '0;
            qwr          = '0;
            n_in_quote   = r_in_quote;
            n_pending    = r_pending;
            n_run_tag    = r_run_tag;
            n_run_active = r_run_active;
            n_run_count  = r_run_count;
            n_lrs        = r_lrs;
            n_prev_tag   = r_prev_tag;
            n_qlen       = r_qlen;
            n_q0_hi      = r_q0_hi;
            n_discard    = !last;
        end
    end

    assign o_push = accept && (cmd.total != '0);
    assign o_cmd  = cmd;
    assign o_qwr  = qwr;

    // A drain stays outstanding until the back end retires its command.
    assign n_drain_busy = (r_drain_busy && !i_drain_done) || (o_push && cmd.drn_en);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote   <= 1'b0;
            r_pending    <= 1'b0;
            r_run_tag    <= '0;
            r_run_active <= 1'b0;
            r_run_count  <= '0;
            r_lrs        <= '0;
            r_prev_tag   <= '0;
            r_qlen       <= '0;
            r_q0_hi      <= 1'b0;
            r_discard    <= 1'b0;
            r_drain_busy <= 1'b0;
        end else begin
            r_drain_busy <= n_drain_busy;
            if (accept) begin
                r_in_quote   <= n_in_quote;
                r_pending    <= n_pending;
                r_run_tag    <= n_run_tag;
                r_run_active <= n_run_active;
                r_run_count  <= n_run_count;
                r_lrs        <= n_lrs;
                r_prev_tag   <= n_prev_tag;
                r_qlen       <= n_qlen;
                r_q0_hi      <= n_q0_hi;
                r_discard    <= n_discard;
            end
        end
    end

endmodule

@@ rtl/dpt_queue.sv @@
// Two-entry command queue between the front end and the back end.
module dpt_queue
    import dpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/dpt_back.sv @@
// Back end: expands each command into code-unit transactions and holds the quoted-text buffer.
module dpt_back
    import dpt_pkg::*;
#(
    parameter int QUOTE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_data,
    output logic        o_pop,
    input  t_qwr        i_qwr,
    output logic        o_drain_done,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_code_unit,
    output logic        o_unit_valid,
    output logic        o_last_unit,
    output logic        o_standalone_month,
    output logic [2:0]  o_error_code
);

    localparam int AW = (QUOTE_DEPTH > 1) ? $clog2(QUOTE_DEPTH) : 1;

    // Segment codes, in emission order.
    localparam logic [2:0] SEG_FL1  = 3'd0;
    localparam logic [2:0] SEG_DRN  = 3'd1;
    localparam logic [2:0] SEG_CH   = 3'd2;
    localparam logic [2:0] SEG_FL2  = 3'd3;
    localparam logic [2:0] SEG_MARK = 3'd4;
    localparam logic [2:0] SEG_ERR  = 3'd5;
    localparam logic [2:0] SEG_DONE = 3'd6;

    logic [7:0]        r_mem [QUOTE_DEPTH];
    logic [7:0]        r_rdata;
    logic [AW-1:0]     rd_addr;

    logic              r_busy;
    t_cmd              r_cmd;
    logic [2:0]        r_seg, n_seg;
    logic [1:0]        r_sub, n_sub;
    logic [LEN_W-1:0]  r_di, n_di;
    logic [NOUT_W-1:0] r_nout;

    logic              r_out_valid;
    logic [15:0]       r_code_unit;
    logic              r_unit_valid;
    logic              r_last_unit;
    logic              r_smonth;
    logic [2:0]        r_err;

    logic              can_emit;
    logic              emit;
    logic              fire;
    logic              seg_end;
    logic              final_unit;
    logic [15:0]       unit;
    logic [TOT_W-1:0]  lim;
    logic [CNT_W-1:0]  fl_cnt;
    logic [TAG_W-1:0]  fl_tag;

    // First segment at or after a given one that has work in the command.
    function automatic logic [2:0] seg_from(input t_cmd c, input logic [2:0] from);
        logic [5:0] flags;
        logic [2:0] s;
        logic       found;
        flags = {c.err != ERR_NONE, c.mark_en, c.fl2_en, c.ch_en, c.drn_en, c.fl1_en};
        s     = SEG_DONE;
        found = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if (!found && flags[k] && (3'(k) >= from)) begin
                s     = 3'(k);
                found = 1'b1;
            end
        end
        return s;
    endfunction

    assign o_pop    = !r_busy && i_q_valid;
    assign can_emit = !r_out_valid || !i_out_stall;
    assign lim      = (r_cmd.total > TOT_W'(MAX_OUT)) ? TOT_W'(MAX_OUT) : r_cmd.total;
    assign fl_cnt   = (r_seg == SEG_FL1) ? r_cmd.fl1_cnt : r_cmd.fl2_cnt;
    assign fl_tag   = (r_seg == SEG_FL1) ? r_cmd.fl1_tag : r_cmd.fl2_tag;

    // Unit generation for the current segment.
    always_comb begin
        emit    = 1'b1;
        seg_end = 1'b0;
        unit    = '0;
        n_sub   = r_sub + 2'd1;
        n_di    = r_di;
        case (r_seg)
            SEG_FL1, SEG_FL2: begin
                case (r_sub)
                    2'd0: unit = {3'b000, fl_tag,
                                  (fl_cnt < 16'd255) ? fl_cnt[7:0] : 8'hff};
                    2'd1: unit = '0;
                    default: unit = fl_cnt;
                endcase
                seg_end = (r_sub == (run_units(fl_cnt) - 2'd1));
            end
            SEG_DRN: begin
                if (r_sub == 2'd0) begin
                    if (r_cmd.drn_short) begin
                        emit = 1'b0;
                    end else begin
                        unit    = {TAG_CHARS, 2'b00, r_cmd.drn_len};
                        seg_end = (r_cmd.drn_len == '0);
                    end
                end else if (r_cmd.drn_short) begin
                    unit    = {TAG_ASCII, r_rdata};
                    seg_end = 1'b1;
                end else begin
                    unit    = {8'h00, r_rdata};
                    n_sub   = r_sub;
                    n_di    = r_di + LEN_W'(1);
                    seg_end = (n_di == r_cmd.drn_len);
                end
            end
            SEG_CH: begin
                if (r_sub == 2'd0) begin
                    unit    = r_cmd.ch_byte[7] ? {TAG_CHARS, 8'd1} : {TAG_ASCII, r_cmd.ch_byte};
                    seg_end = !r_cmd.ch_byte[7];
                end else begin
                    unit    = {8'h00, r_cmd.ch_byte};
                    seg_end = 1'b1;
                end
            end
            SEG_MARK, SEG_ERR: begin
                seg_end = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        n_seg = seg_end ? seg_from(r_cmd, r_seg + 3'd1) : r_seg;
    end

    assign fire         = r_busy && can_emit && emit;
    assign final_unit   = fire && ((TOT_W'(r_nout) + TOT_W'(1)) == lim);
    assign o_drain_done = final_unit && r_cmd.drn_en;

    // Read address runs one byte ahead while a byte is going out.
    assign rd_addr = (fire && (r_seg == SEG_DRN) && (r_sub != 2'd0))
                   ? n_di[AW-1:0] : r_di[AW-1:0];

    // Quoted-text buffer.
    always_ff @(posedge i_clk) begin
        if (i_qwr.en) begin
            r_mem[i_qwr.addr[AW-1:0]] <= i_qwr.data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= SEG_DONE;
            r_sub  <= '0;
            r_di   <= '0;
            r_nout <= '0;
        end else if (!r_busy) begin
            if (i_q_valid) begin
                r_busy <= 1'b1;
                r_seg  <= seg_from(i_q_data, SEG_FL1);
                r_sub  <= '0;
                r_di   <= '0;
                r_nout <= '0;
            end
        end else if (fire) begin
            r_nout <= r_nout + NOUT_W'(1);
            r_di   <= n_di;
            if (final_unit) begin
                r_busy <= 1'b0;
            end else if (seg_end) begin
                r_seg <= n_seg;
                r_sub <= '0;
            end else begin
                r_sub <= n_sub;
            end
        end else if (!emit && (r_seg == SEG_DRN)) begin
            // Single ASCII quoted byte: wait for its read data from the buffer.
            r_sub <= 2'd1;
        end
    end

    // Command register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_code_unit  <= unit;
            r_unit_valid <= (r_seg != SEG_MARK) && (r_seg != SEG_ERR);
            r_last_unit  <= (r_seg == SEG_ERR) || (r_cmd.fin && final_unit);
            r_smonth     <= r_cmd.fin && final_unit && r_cmd.smonth;
            r_err        <= (r_seg == SEG_ERR) ? r_cmd.err : ERR_NONE;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_code_unit        = r_code_unit;
    assign o_unit_valid       = r_unit_valid;
    assign o_last_unit        = r_last_unit;
    assign o_standalone_month = r_smonth;
    assign o_error_code       = r_err;

endmodule

@@ rtl/date_pattern_tokenizer_core.sv @@
// Top level of the date pattern tokenizer: front end, command queue and back end.
//
// The block compiles a date-format pattern, one byte per input transaction, into 16-bit
// code units, one unit per output transaction. The front end takes a byte whenever the
// two-entry command queue has room and no quoted-text readout is outstanding, and turns
// it into at most one command. The back end first loads each command and then emits one
// unit per cycle while the output is not stalled. A byte that causes no output
// transaction pushes no command. Closing a quote reads n buffered bytes out of a
// QUOTE_DEPTH-byte memory at one byte per cycle after a header while the output is not
// stalled. The back end steps through load, header and n bytes; a lone ASCII byte takes
// load, a read wait and its unit instead. The front end takes no further byte until the
// back end has finished the command that holds that readout. Quoted-text memory contents
// are undefined after reset; only bytes written in the current pattern are read.
module date_pattern_tokenizer_core
    import dpt_pkg::*;
#(
    parameter int QUOTE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_pattern_byte,
    input  logic        i_end_of_pattern,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_code_unit,
    output logic        o_unit_valid,
    output logic        o_last_unit,
    output logic        o_standalone_month,
    output logic [2:0]  o_error_code
);

    logic push;
    t_cmd push_cmd;
    t_qwr qwr;
    logic q_full;
    logic q_valid;
    t_cmd q_data;
    logic pop;
    logic drain_done;

    // Byte classification and pattern state.
    dpt_front #(
        .QUOTE_DEPTH(QUOTE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pattern_byte  (i_pattern_byte),
        .i_end_of_pattern(i_end_of_pattern),
        .i_q_full        (q_full),
        .i_drain_done    (drain_done),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .o_qwr           (qwr)
    );

    // Decoupling queue.
    dpt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_cmd),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_data),
        .i_pop  (pop)
    );

    // Unit expansion and output register.
    dpt_back #(
        .QUOTE_DEPTH(QUOTE_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_data          (q_data),
        .o_pop             (pop),
        .i_qwr             (qwr),
        .o_drain_done      (drain_done),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_code_unit       (o_code_unit),
        .o_unit_valid      (o_unit_valid),
        .o_last_unit       (o_last_unit),
        .o_standalone_month(o_standalone_month),
        .o_error_code      (o_error_code)
    );

endmodule
